// ----- hw/rtl/pfa_pkg.sv -----
// Shared types and constants for the page frame allocator.
// Holds the state encoding, status codes, register indexes and range helpers.
// No dependencies.
package pfa_pkg;

	localparam int ADDR_W   = 44;
	localparam int FRAME_W  = 32;
	localparam int BOUNDS_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_LOAD,
		S_WALK,
		S_HOLD
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC = 2'd0,
		ST_FREED = 2'd1,
		ST_OOM   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_INFO    = 3'd6;

	function automatic logic [FRAME_W-1:0] range_start(input logic [BOUNDS_W-1:0] b);
		return b[BOUNDS_W-1:FRAME_W];
	endfunction

	function automatic logic [FRAME_W-1:0] range_end(input logic [BOUNDS_W-1:0] b);
		return b[FRAME_W-1:0];
	endfunction

	function automatic logic in_range(input logic [FRAME_W-1:0] f,
		input logic [BOUNDS_W-1:0] b);
		return (f >= b[BOUNDS_W-1:FRAME_W]) && (f < b[FRAME_W-1:0]);
	endfunction

endpackage

// ----- hw/rtl/page_frame_allocator.sv -----
// Page frame allocator: LIFO free stack in a synchronous RAM plus a bump cursor over regions.
// Path to out_valid: free via S_HOLD; stack pop via S_POP (registered RAM read) and S_HOLD;
// bump alloc via S_WALK, repeated per region or range skip, then S_HOLD, plus S_LOAD for the
// cursor load on the first bump alloc after reset. One transaction at a time; the next is
// accepted the cycle after its result loads. Reset clears stack count, cursor, region index,
// load flag and out_valid; config registers go to defaults, RAM kept. Depends on pfa_pkg.
module page_frame_allocator import pfa_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int MAX_REGIONS = 4,
	parameter int PAGE_BITS   = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [ADDR_W-1:0]    free_addr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    page_addr,
	output logic [STATUS_W-1:0]  status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BOUNDS_W-1:0]  cfg_data
);

	localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int RI_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int FIN_W = ADDR_W - PAGE_BITS;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

	logic [2:0]          region_count_q;
	logic [BOUNDS_W-1:0] region_q [MAX_REGIONS];
	logic [BOUNDS_W-1:0] kernel_q;
	logic [BOUNDS_W-1:0] boot_q;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [FRAME_W-1:0]  cursor_q;
	logic [RI_W-1:0]     ridx_q;
	logic                loaded_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   page_addr_q;
	status_t             status_q;
	logic [FRAME_W-1:0]  res_frame_q;
	status_t             res_status_q;

	logic [FRAME_W-1:0]  stack_mem [STACK_DEPTH];
	logic [FRAME_W-1:0]  rd_data_s1;

	logic                accept;
	logic                stack_full;
	logic                stack_empty;
	logic                mem_we;
	logic                mem_re;
	logic [CNT_W-1:0]    cnt_dec;
	logic [FRAME_W-1:0]  frame_in;
	logic [2:0]          n_eff;
	logic [BOUNDS_W-1:0] cur_region;
	logic [RI_W-1:0]     ridx_next;
	logic                hit_region;
	logic                hit_kernel;
	logic                hit_boot;
	logic                last_region;
	logic                hold_load;

	assign cfg_ready   = 1'b1;
	assign accept      = in_valid && in_ready;
	assign stack_full  = (count_q == DEPTH_CNT);
	assign stack_empty = (count_q == '0);
	assign cnt_dec     = count_q - CNT_W'(1);
	assign frame_in    = FRAME_W'(free_addr[ADDR_W-1:PAGE_BITS]);
	assign mem_we      = accept && (req_type == REQ_FREE) && !stack_full;
	assign mem_re      = accept && (req_type == REQ_ALLOC) && !stack_empty;

	always_comb begin
		if (region_count_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (region_count_q > 3'(MAX_REGIONS)) begin
			n_eff = 3'(MAX_REGIONS);
		end else begin
			n_eff = region_count_q;
		end
	end

	assign cur_region  = region_q[ridx_q];
	assign ridx_next   = ridx_q + RI_W'(1);
	assign hit_region  = in_range(cursor_q, cur_region);
	assign hit_kernel  = in_range(cursor_q, kernel_q);
	assign hit_boot    = in_range(cursor_q, boot_q);
	assign last_region = ((3'(ridx_q) + 3'd1) >= n_eff);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_FREE) begin
						state_d = S_HOLD;
					end else if (!stack_empty) begin
						state_d = S_POP;
					end else if (!loaded_q) begin
						state_d = S_LOAD;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_POP: state_d = S_HOLD;
			S_LOAD: state_d = S_WALK;
			S_WALK: begin
				if (!hit_region) begin
					if (last_region) begin
						state_d = S_HOLD;
					end
				end else if (!hit_kernel && !hit_boot) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		hold_load = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_HOLD: hold_load = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
				hold_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= 3'd1;
			for (int i = 0; i < MAX_REGIONS; i++) begin
				region_q[i] <= '0;
			end
			kernel_q <= '0;
			boot_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_REGION_COUNT) begin
				region_count_q <= cfg_data[2:0];
			end
			for (int i = 0; i < MAX_REGIONS; i++) begin
				if (cfg_index == REG_REGION_0 + CFG_IDX_W'(i)) begin
					region_q[i] <= cfg_data;
				end
			end
			if (cfg_index == REG_KERNEL) begin
				kernel_q <= cfg_data;
			end
			if (cfg_index == REG_BOOT_INFO) begin
				boot_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			ridx_q      <= '0;
			loaded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (mem_re) begin
				count_q <= cnt_dec;
			end
			if (state_q == S_LOAD) begin
				cursor_q <= range_start(region_q[0]);
				ridx_q   <= '0;
				loaded_q <= 1'b1;
			end else if (state_q == S_WALK) begin
				if (!hit_region) begin
					if (!last_region) begin
						ridx_q   <= ridx_next;
						cursor_q <= range_start(region_q[ridx_next]);
					end
				end else if (hit_kernel) begin
					cursor_q <= range_end(kernel_q);
				end else if (hit_boot) begin
					cursor_q <= range_end(boot_q);
				end else begin
					cursor_q <= cursor_q + FRAME_W'(1);
				end
			end
			if (hold_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_FREE)) begin
			res_status_q <= stack_full ? ST_FULL : ST_FREED;
		end
		if (state_q == S_POP) begin
			res_frame_q  <= rd_data_s1;
			res_status_q <= ST_ALLOC;
		end
		if (state_q == S_WALK) begin
			if (!hit_region && last_region) begin
				res_status_q <= ST_OOM;
			end else if (hit_region && !hit_kernel && !hit_boot) begin
				res_frame_q  <= cursor_q;
				res_status_q <= ST_ALLOC;
			end
		end
		if (hold_load) begin
			status_q <= res_status_q;
			if (res_status_q == ST_ALLOC) begin
				page_addr_q <= {res_frame_q[FIN_W-1:0], {PAGE_BITS{1'b0}}};
			end else begin
				page_addr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[count_q[SA_W-1:0]] <= frame_in;
		end
		if (mem_re) begin
			rd_data_s1 <= stack_mem[cnt_dec[SA_W-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign page_addr = page_addr_q;
	assign status    = status_q;

endmodule

// ----- tb/page_frame_allocator_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for page_frame_allocator: alloc/free traffic against a local model
// of the free stack and the region cursor, with register rewrites between bursts.
// Depends on pfa_pkg and page_frame_allocator.
module page_frame_allocator_test;
	import pfa_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int REGION_SLOTS = 4;
	localparam int PAGE_SHIFT   = 12;

	typedef struct {
		logic              kind;
		logic [ADDR_W-1:0] addr;
	} req_item_t;

	typedef struct {
		logic [ADDR_W-1:0] page;
		status_t           code;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 req_type = REQ_ALLOC;
	logic [ADDR_W-1:0]    free_addr = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ADDR_W-1:0]    page_addr;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BOUNDS_W-1:0]  cfg_data = '0;

	req_item_t request_queue[$];
	grant_t    expected_grants[$];
	req_item_t pending;
	grant_t    want;
	int        send_gap = 0;
	int        recv_gap = 0;
	int        in_idle_pct = 0;
	int        out_idle_pct = 0;
	int        fail_count = 0;
	bit        quiet = 1'b0;
	bit        hold_off = 1'b0;

	logic [2:0]          map_count = 3'd1;
	logic [BOUNDS_W-1:0] region_span[REGION_SLOTS] = '{default: '0};
	logic [BOUNDS_W-1:0] kernel_span = '0;
	logic [BOUNDS_W-1:0] boot_span = '0;
	logic [FRAME_W-1:0]  frame_stack[DEPTH];
	int                  stack_fill = 0;
	logic [FRAME_W-1:0]  cursor = '0;
	logic [1:0]          region_sel = '0;
	bit                  cursor_valid = 1'b0;

	page_frame_allocator #(
		.STACK_DEPTH(DEPTH),
		.MAX_REGIONS(REGION_SLOTS),
		.PAGE_BITS(PAGE_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.free_addr(free_addr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.page_addr(page_addr),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit covers(logic [FRAME_W-1:0] f, logic [BOUNDS_W-1:0] span);
		return f >= span[BOUNDS_W-1:FRAME_W] && f < span[FRAME_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] frame_page(logic [FRAME_W-1:0] f);
		return ADDR_W'({f, {PAGE_SHIFT{1'b0}}});
	endfunction

	function automatic grant_t predict_grant(logic kind, logic [ADDR_W-1:0] addr);
		grant_t g;
		int slots;
		bit found;
		bit exhausted;
		g.page = '0;
		g.code = ST_OOM;
		if (kind == REQ_FREE) begin
			if (stack_fill >= DEPTH) begin
				g.code = ST_FULL;
			end else begin
				frame_stack[stack_fill] = addr[ADDR_W-1:PAGE_SHIFT];
				stack_fill++;
				g.code = ST_FREED;
			end
		end else if (stack_fill > 0) begin
			stack_fill--;
			g.page = frame_page(frame_stack[stack_fill]);
			g.code = ST_ALLOC;
		end else begin
			slots = (map_count == 0) ? 1 : ((map_count > REGION_SLOTS) ? REGION_SLOTS : map_count);
			if (!cursor_valid) begin
				cursor = region_span[0][BOUNDS_W-1:FRAME_W];
				region_sel = '0;
				cursor_valid = 1'b1;
			end
			found = 1'b0;
			exhausted = 1'b0;
			while (!found && !exhausted) begin
				if (!covers(cursor, region_span[region_sel])) begin
					if (region_sel + 1 >= slots) begin
						exhausted = 1'b1;
					end else begin
						region_sel++;
						cursor = region_span[region_sel][BOUNDS_W-1:FRAME_W];
					end
				end else if (covers(cursor, kernel_span)) begin
					cursor = kernel_span[FRAME_W-1:0];
				end else if (covers(cursor, boot_span)) begin
					cursor = boot_span[FRAME_W-1:0];
				end else begin
					found = 1'b1;
				end
			end
			if (found) begin
				g.page = frame_page(cursor);
				g.code = ST_ALLOC;
				cursor++;
			end
		end
		return g;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// sender: hold the payload until the request is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_ALLOC;
			free_addr <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				expected_grants.push_back(predict_grant(req_type, free_addr));
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				pending = request_queue.pop_front();
				in_valid <= 1'b1;
				req_type <= pending.kind;
				free_addr <= pending.addr;
				if (!quiet && $urandom_range(99) < in_idle_pct)
					send_gap = $urandom_range(13, 1);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					note_failure($sformatf("mismatch: unexpected result page_addr=%h status=%0d",
						page_addr, status));
				end else begin
					want = expected_grants.pop_front();
					if (page_addr !== want.page || status !== want.code)
						note_failure($sformatf(
							"mismatch: page_addr exp %h got %h, status exp %0d got %0d",
							want.page, page_addr, want.code, status));
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(99) < out_idle_pct) begin
				recv_gap = $urandom_range(12, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOUNDS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_REGION_COUNT: map_count = val[2:0];
			REG_KERNEL:       kernel_span = val;
			REG_BOOT_INFO:    boot_span = val;
			default:          region_span[idx - REG_REGION_0] = val;
		endcase
	endtask

	task automatic add_req(logic kind, logic [ADDR_W-1:0] addr);
		req_item_t item;
		item.kind = kind;
		item.addr = addr;
		request_queue.push_back(item);
	endtask

	task automatic queue_mix(int count, int free_pct);
		@(negedge clk);
		repeat (count)
			add_req(($urandom_range(99) < free_pct) ? REQ_FREE : REQ_ALLOC,
				ADDR_W'({$urandom, $urandom}));
	endtask

	task automatic drain_wait();
		do @(negedge clk);
		while (request_queue.size() != 0 || in_valid || expected_grants.size() != 0);
	endtask

	// keep the active region around the cursor so the walk goes on, with some noise
	task automatic reshape_map();
		logic [FRAME_W-1:0] lo;
		int i;
		write_reg(REG_REGION_COUNT,
			BOUNDS_W'(($urandom_range(3) == 0) ? $urandom_range(7) : 4));
		for (i = 0; i < REGION_SLOTS; i++) begin
			if ($urandom_range(7) == 0) begin
				write_reg(REG_REGION_0 + CFG_IDX_W'(i), {$urandom, $urandom});
			end else if (i == region_sel) begin
				lo = cursor - $urandom_range(3);
				write_reg(REG_REGION_0 + CFG_IDX_W'(i),
					{lo, cursor + FRAME_W'($urandom_range(24))});
			end else begin
				lo = $urandom;
				write_reg(REG_REGION_0 + CFG_IDX_W'(i), {lo, lo + FRAME_W'($urandom_range(20))});
			end
		end
		lo = cursor + $urandom_range(8);
		write_reg(REG_KERNEL, ($urandom_range(5) == 0) ? {$urandom, $urandom}
			: {lo, lo + FRAME_W'($urandom_range(5))});
		lo = cursor + $urandom_range(10);
		write_reg(REG_BOOT_INFO, ($urandom_range(5) == 0) ? {$urandom, $urandom}
			: {lo, lo + FRAME_W'($urandom_range(4))});
	endtask

	task automatic flat_map(logic [BOUNDS_W-1:0] word);
		int i;
		write_reg(REG_REGION_COUNT, BOUNDS_W'(word[2:0]));
		for (i = 0; i < REGION_SLOTS; i++)
			write_reg(REG_REGION_0 + CFG_IDX_W'(i), word);
		write_reg(REG_KERNEL, word);
		write_reg(REG_BOOT_INFO, word);
	endtask

	initial begin
		int phase;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// two regions, the second starting inside the kernel range
		write_reg(REG_REGION_COUNT, BOUNDS_W'(2));
		write_reg(REG_REGION_0, {32'h100, 32'h108});
		write_reg(REG_REGION_0 + CFG_IDX_W'(1), {32'h103, 32'h107});
		write_reg(REG_REGION_0 + CFG_IDX_W'(2), '1);
		write_reg(REG_REGION_0 + CFG_IDX_W'(3), '0);
		write_reg(REG_KERNEL, {32'h102, 32'h104});
		write_reg(REG_BOOT_INFO, {32'h105, 32'h106});
		@(negedge clk);
		repeat (10) add_req(REQ_ALLOC, '0);
		add_req(REQ_FREE, '1);
		add_req(REQ_FREE, '0);
		add_req(REQ_FREE, 44'h000_0000_0ABC);
		add_req(REQ_FREE, 44'h800_0000_0000);
		add_req(REQ_FREE, 44'h800_0000_0FFF);
		repeat (6) add_req(REQ_ALLOC, '1);
		drain_wait();

		for (phase = 0; phase < 18; phase++) begin
			in_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(60);
			out_idle_pct = (phase % 4 == 2) ? 0 : $urandom_range(60);
			quiet = (phase >= 16);
			if (phase == 2)
				flat_map('1);
			else if (phase == 3)
				flat_map('0);
			else
				reshape_map();
			if (phase == 5) begin
				@(posedge clk);
				hold_off <= 1'b1;
			end
			queue_mix($urandom_range(50, 30), 15 + 25 * $urandom_range(2));
			if (phase == 5) begin
				repeat (200) @(posedge clk);
				hold_off <= 1'b0;
			end
			drain_wait();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/pfa_pkg.sv
hw/rtl/page_frame_allocator.sv
tb/page_frame_allocator_test.sv
